// ===== rtl/molw_pkg.sv =====
// ----------------------------------------------------------------------------
// molw_pkg: shared types and constants of the motion-object list walker
// Commands, result kinds, the front-to-back job record and sequencer states.
// ----------------------------------------------------------------------------
package molw_pkg;

	localparam int ObjectCount  = 1024;
	localparam int ScreenTilesX = 42;
	localparam int ScreenTilesY = 30;
	localparam int PlaneDepth   = 1024;

	typedef enum logic [1:0] {
		CMD_WRITE_OBJ  = 2'd0,
		CMD_WRITE_HEAD = 2'd1,
		CMD_BEGIN      = 2'd2,
		CMD_NEXT       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TILE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// one classified command handed from the front to the back
	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  plane;
		logic [9:0]  slot;
		logic [5:0]  row;
		logic [15:0] value;
		logic [8:0]  hs;
		logic [8:0]  vs;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_HEAD_RD,
		ST_HEAD_WAIT,
		ST_OBJ_RD,
		ST_OBJ_WAIT,
		ST_TILE,
		ST_FLUSH,
		ST_EMIT_EMPTY,
		ST_EMIT_DONE
	} state_t;

endpackage

// ===== rtl/molw_front.sv =====
// ----------------------------------------------------------------------------
// molw_front: command intake
// Drops commands that cannot matter and queues the rest for the back end.
// ----------------------------------------------------------------------------
module molw_front #(
	parameter int OBJECT_COUNT = molw_pkg::ObjectCount
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  molw_pkg::job_t   in_job,
	output logic             job_valid,
	input  logic             job_ready,
	output molw_pkg::job_t   job
);

	localparam int Depth = 4;

	molw_pkg::job_t fifo_q [Depth];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       keep;
	logic       push, pop;

	// an object word write to a slot beyond the object count is dropped here
	assign keep = !(in_job.cmd == molw_pkg::CMD_WRITE_OBJ &&
		{22'd0, in_job.slot} >= OBJECT_COUNT);
	assign in_ready  = (count_q != 3'(Depth));
	assign push      = in_valid && in_ready && keep;
	assign job_valid = (count_q != 3'd0);
	assign pop       = job_valid && job_ready;
	assign job       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== rtl/molw_back.sv =====
// ----------------------------------------------------------------------------
// molw_back: list walker and tile expander
// Owns the object planes, row heads and visited map; walks lists and emits
// tile, empty and done items through an output register.
// ----------------------------------------------------------------------------
module molw_back #(
	parameter int OBJECT_COUNT   = molw_pkg::ObjectCount,
	parameter int SCREEN_TILES_X = molw_pkg::ScreenTilesX,
	parameter int SCREEN_TILES_Y = molw_pkg::ScreenTilesY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  molw_pkg::job_t   job,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [9:0]       object_index,
	output logic [14:0]      tile_code,
	output logic [3:0]       palette,
	output logic             mirrored,
	output logic signed [9:0] screen_x,
	output logic signed [8:0] screen_y,
	output logic             last,
	output logic             clearing
);

	localparam logic [9:0] LimX = 10'(8 * SCREEN_TILES_X);
	localparam logic [9:0] LimY = 10'(8 * SCREEN_TILES_Y);

	// memories
	logic [15:0] obj_mem [4096];
	logic [9:0]  head_mem [64];
	logic        vis_mem [1024];
	logic [15:0] obj_rd;
	logic [9:0]  head_rd;
	logic        vis_rd;

	// reset sweep clears all memories, frame start clears the visited map
	molw_pkg::state_t state_q, state_d;
	logic [11:0] clr_q;
	logic        clr_all_q;
	logic [9:0]  link_q;
	logic [5:0]  row_q, walked_q;
	logic [9:0]  xo_q, yo_q;
	logic        open_q;
	logic [1:0]  ph_q;
	logic [15:0] w1_q, w2_q, w3_q;
	logic [2:0]  r_q, c_q;
	logic        any_q;
	logic [9:0]  obj_id_q;

	// a link past the object count ends the row like a visited one
	logic        link_ok;
	assign link_ok = !vis_rd && ({22'd0, link_q} < OBJECT_COUNT);

	logic        ob_full_q;
	logic        ob_free;
	assign ob_free = !ob_full_q || out_ready;

	// memory access selection
	logic [11:0] obj_addr;
	logic        obj_we, head_we, vis_we, vis_wd;
	logic [9:0]  vis_addr;
	logic [5:0]  head_addr;

	always_comb begin
		obj_we = 1'b0; head_we = 1'b0; vis_we = 1'b0; vis_wd = 1'b0;
		obj_addr = {2'd3, link_q};
		vis_addr = link_q;
		head_addr = row_q;
		unique case (state_q)
			molw_pkg::ST_CLEAR: begin
				obj_we = clr_all_q; obj_addr = clr_q;
				head_we = clr_all_q; head_addr = clr_q[5:0];
				vis_we = 1'b1; vis_addr = clr_q[9:0];
			end
			molw_pkg::ST_IDLE: begin
				if (job_valid && job.cmd == molw_pkg::CMD_WRITE_OBJ) begin
					obj_we = 1'b1; obj_addr = {job.plane, job.slot};
				end
				if (job_valid && job.cmd == molw_pkg::CMD_WRITE_HEAD) begin
					head_we = 1'b1; head_addr = job.row;
				end
			end
			molw_pkg::ST_WALK_CHK: begin
				if (link_ok) begin
					vis_we = 1'b1; vis_wd = 1'b1;
				end
			end
			molw_pkg::ST_OBJ_RD: obj_addr = {ph_q, link_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (obj_we) obj_mem[obj_addr] <= (state_q == molw_pkg::ST_CLEAR) ? 16'd0 : job.value;
		obj_rd <= obj_mem[obj_addr];
	end
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_addr] <=
			(state_q == molw_pkg::ST_CLEAR) ? 10'd0 : job.value[9:0];
		head_rd <= head_mem[head_addr];
	end
	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_addr] <= vis_wd;
		vis_rd <= vis_mem[vis_addr];
	end

	// tile geometry
	logic [3:0]  hsize, vsize;
	logic        flip;
	logic [2:0]  col;
	logic [8:0]  ypos, xpos, ty9, tx9;
	logic signed [9:0] ty, tx;
	logic [14:0] code;
	logic        vis_tile, last_tile;
	logic [5:0]  tnum;

	always_comb begin
		vsize = {1'b0, w3_q[2:0]} + 4'd1;
		hsize = {1'b0, w3_q[5:3]} + 4'd1;
		flip  = w3_q[6];
		col   = flip ? (w3_q[5:3] - c_q) : c_q;
		xpos  = xo_q[8:0] + w2_q[15:7];
		ypos  = yo_q[8:0] - w3_q[15:7] - {2'd0, vsize, 3'd0};
		ty9   = ypos + {3'd0, r_q, 3'd0};
		tx9   = xpos + {3'd0, col, 3'd0};
		ty    = (ty9 > 9'h1f8) ? $signed({1'b1, ty9}) : $signed({1'b0, ty9});
		tx    = (tx9 > 9'h1f8) ? $signed({1'b1, tx9}) : $signed({1'b0, tx9});
		tnum  = ({3'd0, r_q} * {2'd0, hsize}) + {3'd0, c_q};
		code  = (w1_q[14:0] + {9'd0, tnum}) ^ 15'h800;
		vis_tile = (ty < $signed(LimY)) && (tx < $signed(LimX));
		last_tile = (r_q == w3_q[2:0]) && (c_q == w3_q[5:3]);
	end

	logic ob_load;
	logic [1:0] nk;
	logic nl;
	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		ob_load = 1'b0;
		nk = molw_pkg::KIND_TILE;
		nl = 1'b0;
		unique case (state_q)
			molw_pkg::ST_CLEAR: if (clr_q[9:0] == 10'h3ff && (!clr_all_q || &clr_q))
				state_d = molw_pkg::ST_IDLE;
			molw_pkg::ST_IDLE: if (job_valid) begin
				job_ready = 1'b1;
				unique case (job.cmd)
					molw_pkg::CMD_BEGIN:  state_d = molw_pkg::ST_HEAD_RD;
					molw_pkg::CMD_NEXT:
						state_d = open_q ? molw_pkg::ST_WALK_RD : molw_pkg::ST_EMIT_DONE;
					default: ;
				endcase
			end
			molw_pkg::ST_HEAD_RD:   state_d = molw_pkg::ST_HEAD_WAIT;
			molw_pkg::ST_HEAD_WAIT: state_d = open_q ? molw_pkg::ST_WALK_RD : molw_pkg::ST_CLEAR;
			molw_pkg::ST_WALK_RD:   state_d = molw_pkg::ST_WALK_CHK;
			molw_pkg::ST_WALK_CHK:
				if (link_ok) state_d = molw_pkg::ST_OBJ_RD;
				else if (walked_q >= 6'(SCREEN_TILES_Y)) state_d = molw_pkg::ST_EMIT_DONE;
				else state_d = molw_pkg::ST_HEAD_RD;
			molw_pkg::ST_OBJ_RD:    state_d = molw_pkg::ST_OBJ_WAIT;
			molw_pkg::ST_OBJ_WAIT:
				state_d = (ph_q == 2'd3) ? molw_pkg::ST_TILE : molw_pkg::ST_OBJ_RD;
			molw_pkg::ST_TILE: if (ob_free) begin
				// every visible tile goes to the hold stage first
				ob_load = vis_tile;
				if (last_tile) state_d = (any_q || vis_tile) ?
					molw_pkg::ST_FLUSH : molw_pkg::ST_EMIT_EMPTY;
			end
			molw_pkg::ST_FLUSH: if (ob_free) state_d = molw_pkg::ST_IDLE;
			molw_pkg::ST_EMIT_EMPTY: if (ob_free) begin
				ob_load = 1'b1; nk = molw_pkg::KIND_EMPTY; nl = 1'b1;
				state_d = molw_pkg::ST_IDLE;
			end
			molw_pkg::ST_EMIT_DONE: if (ob_free) begin
				ob_load = 1'b1; nk = molw_pkg::KIND_DONE; nl = 1'b1;
				state_d = molw_pkg::ST_IDLE;
			end
			default: state_d = molw_pkg::ST_IDLE;
		endcase
	end

	// a visible tile that is not last marks last only if no later tile shows;
	// hold one tile back so the last flag is exact
	logic        pend_q;
	logic [1:0]  pk_q;
	logic [9:0]  pi_q;
	logic [14:0] pc_q;
	logic [3:0]  pp_q;
	logic        pm_q;
	logic signed [9:0] px_q;
	logic signed [8:0] py_q;

	// release the held tile as the last one of its object
	logic flush_last;
	logic ob_set;
	assign flush_last = state_q == molw_pkg::ST_FLUSH && ob_free;
	assign ob_set = (ob_load && (nl || pend_q)) || flush_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= molw_pkg::ST_CLEAR;
			clr_q <= '0; clr_all_q <= 1'b1;
			link_q <= '0; row_q <= '0; walked_q <= '0;
			xo_q <= '0; yo_q <= '0; open_q <= 1'b0;
			ph_q <= '0; r_q <= '0; c_q <= '0; any_q <= 1'b0;
			w1_q <= '0; w2_q <= '0; w3_q <= '0;
			ob_full_q <= 1'b0; pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ob_full_q <= ob_set || (ob_full_q && !out_ready);
			unique case (state_q)
				molw_pkg::ST_CLEAR: begin
					if (state_d == molw_pkg::ST_IDLE) begin
						clr_q <= '0; clr_all_q <= 1'b0;
					end else clr_q <= clr_q + 12'd1;
				end
				molw_pkg::ST_IDLE: if (job_valid && job.cmd == molw_pkg::CMD_BEGIN) begin
					xo_q <= 10'd0 - {1'b0, job.hs};
					yo_q <= 10'd0 - {1'b0, job.vs};
					row_q <= job.vs[8:3];
					walked_q <= '0;
					open_q <= 1'b0;
				end
				molw_pkg::ST_HEAD_WAIT: begin
					link_q <= head_rd;
					if (!open_q) open_q <= 1'b1;
				end
				molw_pkg::ST_WALK_CHK:
					if (link_ok) ph_q <= 2'd0;
					else if (walked_q >= 6'(SCREEN_TILES_Y)) open_q <= 1'b0;
					else begin
						walked_q <= walked_q + 6'd1;
						row_q <= row_q + 6'd1;
					end
				molw_pkg::ST_OBJ_WAIT: begin
					unique case (ph_q)
						2'd0: w1_q <= obj_rd;
						2'd1: w2_q <= obj_rd;
						2'd2: w3_q <= obj_rd;
						default: link_q <= obj_rd[9:0];
					endcase
					ph_q <= ph_q + 2'd1;
					r_q <= '0; c_q <= '0; any_q <= 1'b0;
				end
				molw_pkg::ST_TILE: if (ob_free) begin
					if (vis_tile) any_q <= 1'b1;
					if (c_q == w3_q[5:3]) begin
						c_q <= '0; r_q <= r_q + 3'd1;
					end else c_q <= c_q + 3'd1;
				end
				default: ;
			endcase
			if (ob_load) pend_q <= !nl && nk == molw_pkg::KIND_TILE;
			else if (flush_last) pend_q <= 1'b0;
		end
	end

	// the expanded object is the one read before link_q was advanced
	always_ff @(posedge clk) begin
		if (state_q == molw_pkg::ST_WALK_CHK) obj_id_q <= link_q;
	end

	// output register and one-deep hold stage
	always_ff @(posedge clk) begin
		if (ob_load) begin
			if (nl) begin
				kind <= nk; last <= 1'b1;
				object_index <= (nk == molw_pkg::KIND_DONE) ? 10'd0 : obj_id_q;
				tile_code <= (nk == molw_pkg::KIND_TILE) ? code : 15'd0;
				palette <= (nk == molw_pkg::KIND_TILE) ? w2_q[3:0] : 4'd0;
				mirrored <= (nk == molw_pkg::KIND_TILE) ? flip : 1'b0;
				screen_x <= (nk == molw_pkg::KIND_TILE) ? tx : 10'sd0;
				screen_y <= (nk == molw_pkg::KIND_TILE) ? ty[8:0] : 9'sd0;
			end else if (pend_q) begin
				kind <= pk_q; object_index <= pi_q; tile_code <= pc_q;
				palette <= pp_q; mirrored <= pm_q; screen_x <= px_q;
				screen_y <= py_q; last <= 1'b0;
			end
			pk_q <= nk; pi_q <= obj_id_q; pc_q <= code; pp_q <= w2_q[3:0];
			pm_q <= flip; px_q <= tx; py_q <= ty[8:0];
		end else if (flush_last) begin
			kind <= pk_q; object_index <= pi_q; tile_code <= pc_q;
			palette <= pp_q; mirrored <= pm_q; screen_x <= px_q;
			screen_y <= py_q; last <= 1'b1;
		end
	end

	assign out_valid = ob_full_q;
	assign clearing  = state_q == molw_pkg::ST_CLEAR;

endmodule

// ===== rtl/motion_object_list_walker.sv =====
// ----------------------------------------------------------------------------
// motion_object_list_walker: motion-object list walker
// Walks per-row object lists and expands each object into tile items.
// ----------------------------------------------------------------------------
// Next: a next command walks its row list: it reads and checks the link, reads the
// object's four words, and reads the next row head for each row skipped; then it
// gives one tile position per cycle while the output is free (up to 64), then the held last tile.
// Commands: the back end takes one command at a time; a begin frame also runs a
// pass that clears the visited map.
// Reset: control clears at once; a pass then zeroes planes, heads, visited map.
module motion_object_list_walker #(
	parameter int OBJECT_COUNT   = molw_pkg::ObjectCount,
	parameter int SCREEN_TILES_X = molw_pkg::ScreenTilesX,
	parameter int SCREEN_TILES_Y = molw_pkg::ScreenTilesY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [1:0]  plane,
	input  logic [9:0]  object_slot,
	input  logic [5:0]  list_row,
	input  logic [15:0] word_value,
	input  logic [8:0]  horizontal_scroll,
	input  logic [8:0]  vertical_scroll,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [9:0]  object_index,
	output logic [14:0] tile_code,
	output logic [3:0]  palette,
	output logic        mirrored,
	output logic signed [9:0] screen_x,
	output logic signed [8:0] screen_y,
	output logic        last
);

	molw_pkg::job_t in_job, job;
	logic job_valid, job_ready, clearing;

	assign in_job = '{cmd: molw_pkg::cmd_t'(command), plane: plane, slot: object_slot,
		row: list_row, value: word_value, hs: horizontal_scroll, vs: vertical_scroll};

	molw_front #(.OBJECT_COUNT(OBJECT_COUNT)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_job,
		.job_valid, .job_ready, .job
	);

	molw_back #(.OBJECT_COUNT(OBJECT_COUNT), .SCREEN_TILES_X(SCREEN_TILES_X),
		.SCREEN_TILES_Y(SCREEN_TILES_Y)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.out_valid, .out_ready, .kind, .object_index, .tile_code, .palette,
		.mirrored, .screen_x, .screen_y, .last, .clearing
	);

`ifndef SYNTHESIS
	a_no_job_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !job_ready) else $error("job taken during clear");
	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == molw_pkg::KIND_DONE) |-> (last && object_index == 10'd0))
		else $error("frame done item malformed");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == molw_pkg::KIND_EMPTY) |-> last)
		else $error("empty item without last");
`endif

endmodule
